// File: hw/rtl/shake_counter_hysteresis_top_defines.svh
// assertion macros for the shake counter checker
`ifndef SHAKE_COUNTER_HYSTERESIS_TOP_DEFINES_SVH
`define SHAKE_COUNTER_HYSTERESIS_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define SCH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define SCH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/sch_pkg.sv
// types, constants and filter helpers for the shake counter
package sch_pkg;

    // low-pass smoothing: alpha = 2^-SMOOTHING_SHIFT
    localparam int unsigned SMOOTHING_SHIFT = 6;

    localparam int unsigned IN_DATA_W  = 64;
    localparam int unsigned OUT_DATA_W = 48;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_COUNTING  = 2'd0,
        STATUS_DONE      = 2'd1,
        STATUS_TIMEOUT   = 2'd2,
        STATUS_IDLE      = 2'd3
    } status_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_HIGH_THRESHOLD = 2'd0,
        REG_LOW_THRESHOLD  = 2'd1,
        REG_SHAKE_TARGET   = 2'd2,
        REG_TIMEOUT_LIMIT  = 2'd3
    } cfg_index_t;

    // input word modes
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_START  = 1'b1;

    // configuration reset values
    localparam logic [16:0] HIGH_THRESHOLD_RST = 17'd6000;
    localparam logic [16:0] LOW_THRESHOLD_RST  = 17'd2000;
    localparam logic [7:0]  SHAKE_TARGET_RST   = 8'd10;
    localparam logic [31:0] TIMEOUT_LIMIT_RST  = 32'd30000;

    localparam logic [15:0] ELAPSED_CAP = 16'hFFFE;
    localparam logic [7:0]  COUNT_MAX   = 8'hFF;

    // one ema step on a q8 filter value
    function automatic logic signed [23:0] ema_update(
        input logic signed [23:0] lpf,
        input logic signed [15:0] smp
    );
        logic signed [24:0] diff;
        logic signed [24:0] step;
        logic signed [24:0] sum;
        diff = {smp[15], smp, 8'd0} - {lpf[23], lpf};
        step = diff >>> SMOOTHING_SHIFT;
        sum  = {lpf[23], lpf} + step;
        return sum[23:0];
    endfunction

    // |sample - floor(lpf / 256)|
    function automatic logic [15:0] hp_mag(
        input logic signed [15:0] smp,
        input logic signed [23:0] lpf
    );
        logic signed [16:0] d;
        logic [16:0] m;
        d = {smp[15], smp} - {lpf[23], lpf[23:8]};
        m = d[16] ? 17'(-d) : d;
        return m[15:0];
    endfunction

endpackage

// File: hw/rtl/shake_counter_hysteresis_top.sv
// shake counter: high-pass energy with hysteresis, target and timeout
//
// Takes one word per cycle while the result stream is not stalled, and returns
// exactly one result word per input word. A word passes an input register, then
// the filter update, energy sum, threshold compares and count/timeout checks that
// also update the run state, then lands in the result register. The input
// register keeps taking words while a result waits for m_tready, as long as
// it is free. Configuration writes are taken at any time (cfg_ready is always
// high) and must only be issued while no word is in flight.
module shake_counter_hysteresis_top (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // accel_x[15:0], accel_z[31:16], now_ms[63:32]
    input  logic        s_tuser,   // mode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // run_ms[15:0], shake_count[23:16], energy[40:24], zero
    output logic [1:0]  m_tuser,   // status
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import sch_pkg::*;

    // configuration registers
    logic [16:0] high_thr_reg;
    logic [16:0] low_thr_reg;
    logic [7:0]  target_reg;
    logic [31:0] limit_reg;

    // input register
    logic        in_valid_reg;
    logic [63:0] in_data_reg;
    logic        in_mode_reg;

    // run state
    logic signed [23:0] filt_x_reg, filt_x_next;
    logic signed [23:0] filt_z_reg, filt_z_next;
    logic               seeded_reg, seeded_next;
    logic               armed_reg,  armed_next;
    logic [7:0]         count_reg,  count_next;
    logic [31:0]        start_reg,  start_next;
    logic               running_reg, running_next;

    // result register
    logic        out_valid_reg;
    logic [47:0] out_data_reg, out_data_next;
    status_t     out_status_reg, out_status_next;

    logic advance;
    logic fire;

    logic signed [15:0] ax;
    logic signed [15:0] az;
    logic [31:0]        now;
    logic signed [23:0] ema_x;
    logic signed [23:0] ema_z;
    logic [16:0]        energy;
    logic [31:0]        elapsed;
    logic [15:0]        elapsed_sat;
    logic [16:0]        energy_out;
    logic [15:0]        elapsed_out;

    // handshake control
    assign advance   = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

    // unpack the held word
    assign ax  = in_data_reg[15:0];
    assign az  = in_data_reg[31:16];
    assign now = in_data_reg[63:32];

    // filter and energy datapath
    assign ema_x       = ema_update(filt_x_reg, ax);
    assign ema_z       = ema_update(filt_z_reg, az);
    assign energy      = {1'b0, hp_mag(ax, ema_x)} + {1'b0, hp_mag(az, ema_z)};
    assign elapsed     = now - start_reg;
    assign elapsed_sat = (elapsed > {16'd0, ELAPSED_CAP}) ? ELAPSED_CAP : elapsed[15:0];

    // per-word state update and result
    always_comb begin
        filt_x_next     = filt_x_reg;
        filt_z_next     = filt_z_reg;
        seeded_next     = seeded_reg;
        armed_next      = armed_reg;
        count_next      = count_reg;
        start_next      = start_reg;
        running_next    = running_reg;
        out_status_next = STATUS_COUNTING;
        energy_out      = 17'd0;
        elapsed_out     = 16'd0;
        if (in_mode_reg == MODE_START) begin
            count_next   = 8'd0;
            armed_next   = 1'b0;
            seeded_next  = 1'b0;
            start_next   = now;
            running_next = 1'b1;
        end else if (!running_reg) begin
            out_status_next = STATUS_IDLE;
        end else if (!seeded_reg) begin
            filt_x_next = {ax, 8'd0};
            filt_z_next = {az, 8'd0};
            seeded_next = 1'b1;
        end else begin
            filt_x_next = ema_x;
            filt_z_next = ema_z;
            energy_out  = energy;
            // hysteresis: arm above high, count below low
            if (!armed_reg) begin
                if (energy > high_thr_reg) begin
                    armed_next = 1'b1;
                end
            end else if (energy < low_thr_reg) begin
                if (count_reg != COUNT_MAX) begin
                    count_next = count_reg + 8'd1;
                end
                armed_next = 1'b0;
            end
            // finish checks
            if (count_next >= target_reg) begin
                out_status_next = STATUS_DONE;
                elapsed_out     = elapsed_sat;
                running_next    = 1'b0;
            end else if (elapsed > limit_reg) begin
                out_status_next = STATUS_TIMEOUT;
                running_next    = 1'b0;
            end
        end
        out_data_next = {7'd0, energy_out, count_next, elapsed_out};
    end

    // configuration write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_thr_reg <= HIGH_THRESHOLD_RST;
            low_thr_reg  <= LOW_THRESHOLD_RST;
            target_reg   <= SHAKE_TARGET_RST;
            limit_reg    <= TIMEOUT_LIMIT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index_t'(cfg_index))
                REG_HIGH_THRESHOLD: high_thr_reg <= cfg_data[16:0];
                REG_LOW_THRESHOLD:  low_thr_reg  <= cfg_data[16:0];
                REG_SHAKE_TARGET:   target_reg   <= cfg_data[7:0];
                REG_TIMEOUT_LIMIT:  limit_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
            in_mode_reg <= s_tuser;
        end
    end

    // run state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filt_x_reg    <= '0;
            filt_z_reg    <= '0;
            seeded_reg    <= 1'b0;
            armed_reg     <= 1'b0;
            count_reg     <= 8'd0;
            start_reg     <= 32'd0;
            running_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                out_valid_reg <= fire;
            end
            if (fire) begin
                filt_x_reg  <= filt_x_next;
                filt_z_reg  <= filt_z_next;
                seeded_reg  <= seeded_next;
                armed_reg   <= armed_next;
                count_reg   <= count_next;
                start_reg   <= start_next;
                running_reg <= running_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg   <= out_data_next;
            out_status_reg <= out_status_next;
        end
    end

endmodule

// File: hw/rtl/sch_checker.sv
// port-level checks for the shake counter, bound to the top level
`include "shake_counter_hysteresis_top_defines.svh"

module sch_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import sch_pkg::*;

    // elapsed time shows only on a finished run, and then stays at or under the cap
    `SCH_ASSERT_NOW(a_elapsed_only_done, aclk, aresetn,
        m_tvalid && (m_tuser != STATUS_DONE), m_tdata[15:0] == 16'd0,
        "elapsed time reported on a word that is not done")
    `SCH_ASSERT_NOW(a_elapsed_capped, aclk, aresetn,
        m_tvalid && (m_tuser == STATUS_DONE), m_tdata[15:0] != 16'hFFFF,
        "elapsed time above the cap")

    // not-running words carry no energy and no pad bits are set
    `SCH_ASSERT_NOW(a_idle_no_energy, aclk, aresetn,
        m_tvalid && (m_tuser == STATUS_IDLE), m_tdata[47:24] == 24'd0,
        "energy reported while not running")

    // a stalled result word holds
    `SCH_ASSERT_NEXT(a_out_hold, aclk, aresetn,
        m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser),
        "result word changed while stalled")

endmodule

bind shake_counter_hysteresis_top sch_checker u_sch_checker (.*);
